>>> rtl/mid_pkg.sv
package mid_pkg;

  // Instruction word fields
  localparam int unsigned OpcodeLsb = 26;

  // Opcode and function code landmarks
  localparam logic [5:0] OP_SPECIAL    = 6'd0;
  localparam logic [5:0] OP_IMM_FIRST  = 6'd8;
  localparam logic [5:0] OP_IMM_LAST   = 6'd15;
  localparam logic [5:0] OP_LOAD_FIRST = 6'd32;
  localparam logic [5:0] OP_LOAD_LAST  = 6'd38;
  localparam logic [5:0] OP_STORE_FIRST = 6'd40;
  localparam logic [5:0] OP_STORE_WORD = 6'd43;
  localparam logic [5:0] OP_LS_LAST    = 6'd46;

  localparam logic [5:0] FN_ALU_FIRST  = 6'd32;
  localparam logic [5:0] FN_ALU_LAST   = 6'd39;
  localparam logic [5:0] FN_SLT        = 6'd42;
  localparam logic [5:0] FN_SLTU       = 6'd43;

  // Shift kind from the low two function bits
  localparam logic [1:0] SH_FN_SLL = 2'd0;
  localparam logic [1:0] SH_FN_SRL = 2'd2;
  localparam logic [1:0] SH_FN_SRA = 2'd3;

  // Operation codes that are not a plain offset
  localparam logic [3:0] OPN_SLL  = 4'd0;
  localparam logic [3:0] OPN_SRL  = 4'd1;
  localparam logic [3:0] OPN_SRA  = 4'd2;
  localparam logic [3:0] OPN_SLT  = 4'd8;
  localparam logic [3:0] OPN_SLTU = 4'd9;
  localparam logic [3:0] OPN_SWR  = 4'd6;

  // Instruction classes
  localparam logic [2:0] CL_NOP    = 3'd0;
  localparam logic [2:0] CL_SHIFT  = 3'd1;
  localparam logic [2:0] CL_VSHIFT = 3'd2;
  localparam logic [2:0] CL_ALU    = 3'd3;
  localparam logic [2:0] CL_ALUI   = 3'd4;
  localparam logic [2:0] CL_LOAD   = 3'd5;
  localparam logic [2:0] CL_STORE  = 3'd6;

  // Fault codes
  localparam logic [1:0] F_NONE      = 2'd0;
  localparam logic [1:0] F_UNALIGNED = 2'd1;
  localparam logic [1:0] F_UNKNOWN   = 2'd2;

  // Stream widths
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 48;

  // Decoded result
  typedef struct packed {
    logic [1:0]  fault;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [4:0]  dst_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  src_reg;
    logic [3:0]  operation;
    logic [2:0]  insn_class;
  } dec_res_t;

endpackage

>>> rtl/mid_decode.sv
module mid_decode (
  input  logic [31:0]       fetch_address,
  input  logic [31:0]       instruction_word,
  output mid_pkg::dec_res_t res
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [15:0] imm;

  assign opc = instruction_word[31:mid_pkg::OpcodeLsb];
  assign rs  = instruction_word[25:21];
  assign rt  = instruction_word[20:16];
  assign rd  = instruction_word[15:11];
  assign sa  = instruction_word[10:6];
  assign fn  = instruction_word[5:0];
  assign imm = instruction_word[15:0];

  // Field decode; anything not matched falls through as unknown
  always_comb begin
    res = '0;
    res.fault = mid_pkg::F_UNKNOWN;
    if (fetch_address[1:0] != 2'b00) begin
      res.fault = mid_pkg::F_UNALIGNED;
    end else if (instruction_word == 32'd0) begin
      res.fault = mid_pkg::F_NONE;
    end else if (opc == mid_pkg::OP_SPECIAL) begin
      if (fn[5:3] == 3'd0) begin
        // fixed and variable shifts
        if (fn[1:0] != 2'd1) begin
          res.fault   = mid_pkg::F_NONE;
          res.tgt_reg = rt;
          res.dst_reg = rd;
          unique case (fn[1:0])
            mid_pkg::SH_FN_SLL: res.operation = mid_pkg::OPN_SLL;
            mid_pkg::SH_FN_SRL: res.operation = mid_pkg::OPN_SRL;
            default:            res.operation = mid_pkg::OPN_SRA;
          endcase
          if (fn[2]) begin
            res.insn_class = mid_pkg::CL_VSHIFT;
            res.src_reg    = rs;
          end else begin
            res.insn_class   = mid_pkg::CL_SHIFT;
            res.shift_amount = sa;
          end
        end
      end else if (fn >= mid_pkg::FN_ALU_FIRST && fn <= mid_pkg::FN_ALU_LAST) begin
        res.fault      = mid_pkg::F_NONE;
        res.insn_class = mid_pkg::CL_ALU;
        res.operation  = {1'b0, fn[2:0]};
        res.src_reg    = rs;
        res.tgt_reg    = rt;
        res.dst_reg    = rd;
      end else if (fn == mid_pkg::FN_SLT || fn == mid_pkg::FN_SLTU) begin
        res.fault      = mid_pkg::F_NONE;
        res.insn_class = mid_pkg::CL_ALU;
        res.operation  = (fn == mid_pkg::FN_SLT) ? mid_pkg::OPN_SLT : mid_pkg::OPN_SLTU;
        res.src_reg    = rs;
        res.tgt_reg    = rt;
        res.dst_reg    = rd;
      end
    end else if (opc >= mid_pkg::OP_IMM_FIRST && opc <= mid_pkg::OP_IMM_LAST) begin
      res.fault      = mid_pkg::F_NONE;
      res.insn_class = mid_pkg::CL_ALUI;
      res.operation  = {1'b0, opc[2:0]};
      res.src_reg    = rs;
      res.tgt_reg    = rt;
      res.immediate  = imm;
    end else if (opc >= mid_pkg::OP_LOAD_FIRST && opc <= mid_pkg::OP_LOAD_LAST) begin
      res.fault      = mid_pkg::F_NONE;
      res.insn_class = mid_pkg::CL_LOAD;
      res.operation  = {1'b0, opc[2:0]};
      res.src_reg    = rs;
      res.tgt_reg    = rt;
      res.immediate  = imm;
    end else if ((opc >= mid_pkg::OP_STORE_FIRST && opc <= mid_pkg::OP_STORE_WORD)
                 || opc == mid_pkg::OP_LS_LAST) begin
      res.fault      = mid_pkg::F_NONE;
      res.insn_class = mid_pkg::CL_STORE;
      // swr sits apart from the other store opcodes
      res.operation  = (opc == mid_pkg::OP_LS_LAST) ? mid_pkg::OPN_SWR : {2'b00, opc[1:0]};
      res.src_reg    = rs;
      res.tgt_reg    = rt;
      res.immediate  = imm;
    end
  end

endmodule

>>> rtl/mips_instruction_decoder.sv
// Path: a request that is taken goes into the input register, is decoded combinationally,
// and its result is captured in the result register, from which it is offered downstream.
// Throughput: one request per cycle while the output is not stalled; the decode is a single combinational pass.
// A request is taken while a result waits, as long as the input register is free.
// Reset (rst, synchronous, active high) empties both stages; no other state.
module mips_instruction_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [31:0] fetch_address, [63:32] instruction_word
  input  logic [mid_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [2:0] insn_class, [6:3] operation, [11:7] src_reg, [16:12] tgt_reg,
  // [21:17] dst_reg, [26:22] shift_amount, [42:27] immediate, [44:43] fault,
  // [47:45] zero
  output logic [mid_pkg::OutDataW-1:0]  m_tdata
);

  logic              in_valid;
  logic [31:0]       in_addr;
  logic [31:0]       in_word;
  logic              out_valid;
  mid_pkg::dec_res_t out_res;
  mid_pkg::dec_res_t dec_res;
  logic              advance;

  // Result stage moves when empty or drained this cycle
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_addr <= s_tdata[31:0];
      in_word <= s_tdata[63:32];
    end
  end

  mid_decode u_decode (
    .fetch_address    (in_addr),
    .instruction_word (in_word),
    .res              (dec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(mid_pkg::OutDataW - $bits(mid_pkg::dec_res_t)){1'b0}}, out_res};

endmodule
